@@ rtl/core/smw_pkg.sv @@
`default_nettype none
package smw_pkg;

  localparam int WINDOW_MAX_DEFAULT = 64;
  localparam int SAMPLE_W           = 32;
  localparam int MEDIAN_W           = 33;
  localparam int WSIZE_W            = 7;
  localparam logic [WSIZE_W-1:0] WSIZE_RESET = 7'd3;

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DOWN   = 2'd1;
  localparam logic [1:0] MODE_UP     = 2'd2;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic le_d;
    logic le_v;
  } smw_flags_t;

  typedef struct packed {
    logic       upd;
    logic [1:0] mode;
  } smw_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/core/sliding_window_median.sv @@
// Each accepted item steps through S_UPD (chain update), S_PICK (median pick) and
//   S_SUM, where median_twice loads and out_valid rises once the output is free.
//   in_ready is high only in S_IDLE; items before the window fills skip S_PICK and S_SUM.
// Reset: rst (synchronous) empties the window and sets window_size to 3;
//   sample storage needs no clearing pass.
`default_nettype none
module sliding_window_median #(
  parameter int WINDOW_MAX = smw_pkg::WINDOW_MAX_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [smw_pkg::SAMPLE_W-1:0] sample,
  input  wire logic                          restart,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [smw_pkg::MEDIAN_W-1:0] median_twice,
  input  wire logic                          cfg_wr_en,
  input  wire logic [smw_pkg::WSIZE_W-1:0]   cfg_wr_data
);
  import smw_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);
  localparam int POS_W = $clog2(WINDOW_MAX);
  localparam int CW    = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_UPD  = 2'd1;
  localparam logic [1:0] S_PICK = 2'd2;
  localparam logic [1:0] S_SUM  = 2'd3;

  logic [1:0]         state;
  logic [WSIZE_W-1:0] window_size;
  logic [CNT_W-1:0]   fill;
  logic [POS_W-1:0]   pos;
  logic               full;
  logic               emit;
  sample_t            v;
  sample_t            d;
  sample_t            ring [WINDOW_MAX];

  logic [CW-1:0]      ws_ext;
  logic [CNT_W-1:0]   w;
  logic [CNT_W-1:0]   half;
  logic [CNT_W-1:0]   lo_idx;
  logic               accept;
  logic [POS_W-1:0]   pos_eff;
  logic [CNT_W-1:0]   fill_eff;
  logic [CNT_W-1:0]   pos_inc;
  smw_ctrl_t          ctrl;
  logic               pick;
  logic               out_load;
  sample_t            lo_val;
  sample_t            hi_val;

  assign ws_ext = CW'(window_size);
  always_comb begin
    if (ws_ext == '0) begin
      w = CNT_W'(1);
    end else if (ws_ext > CW'(WINDOW_MAX)) begin
      w = CNT_W'(WINDOW_MAX);
    end else begin
      w = ws_ext[CNT_W-1:0];
    end
  end

  assign half   = w >> 1;
  assign lo_idx = w[0] ? half : half - CNT_W'(1);

  assign in_ready = (state == S_IDLE) && !rst;
  assign accept   = in_valid && in_ready;

  assign pos_eff  = (restart || CNT_W'(pos) >= w) ? '0 : pos;
  assign fill_eff = (restart || fill > w) ? '0 : fill;
  assign pos_inc  = CNT_W'(pos_eff) + CNT_W'(1);

  assign ctrl.upd  = (state == S_UPD);
  assign ctrl.mode = !full ? MODE_INSERT : ((v >= d) ? MODE_DOWN : MODE_UP);
  assign pick      = (state == S_PICK);
  assign out_load  = (state == S_SUM) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (accept) begin
      d                  <= ring[pos_eff];
      ring[pos_eff]      <= sample;
      v                  <= sample;
      full               <= (fill_eff == w);
      emit               <= (fill_eff == w) || (fill_eff + CNT_W'(1) == w);
    end
    if (out_load) begin
      median_twice <= MEDIAN_W'(lo_val) + MEDIAN_W'(hi_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      window_size <= WSIZE_RESET;
      fill        <= '0;
      pos         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            fill  <= fill_eff;
            pos   <= (pos_inc >= w) ? '0 : pos_inc[POS_W-1:0];
            state <= S_UPD;
          end
        end
        S_UPD: begin
          fill  <= fill + CNT_W'(!full);
          state <= emit ? S_PICK : S_IDLE;
        end
        S_PICK: begin
          state <= S_SUM;
        end
        S_SUM: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_wr_en) begin
        window_size <= cfg_wr_data;
        fill        <= '0;
        pos         <= '0;
      end
    end
  end

  smw_chain #(
    .WINDOW_MAX(WINDOW_MAX),
    .CNT_W     (CNT_W)
  ) u_chain (
    .clk   (clk),
    .ctrl  (ctrl),
    .fill  (fill),
    .v     (v),
    .d     (d),
    .pick  (pick),
    .lo_idx(lo_idx),
    .hi_idx(half),
    .lo_val(lo_val),
    .hi_val(hi_val)
  );

endmodule
`default_nettype wire

@@ rtl/core/smw_cell.sv @@
`default_nettype none
module smw_cell (
  input  wire logic               clk,
  input  wire smw_pkg::smw_ctrl_t ctrl,
  input  wire logic               valid,
  input  wire smw_pkg::sample_t   v,
  input  wire smw_pkg::sample_t   d,
  input  wire smw_pkg::sample_t   left_val,
  input  wire smw_pkg::smw_flags_t left_flags,
  input  wire smw_pkg::sample_t   right_val,
  input  wire smw_pkg::smw_flags_t right_flags,
  output smw_pkg::sample_t        val,
  output smw_pkg::smw_flags_t     flags
);
  import smw_pkg::*;

  sample_t val_next;

  assign flags.le_d = valid && (val <= d);
  assign flags.le_v = valid && (val <= v);

  always_comb begin
    val_next = val;
    unique case (ctrl.mode)
      MODE_INSERT: begin
        if (!flags.le_v) begin
          val_next = left_flags.le_v ? v : left_val;
        end
      end
      MODE_DOWN: begin
        if (!right_flags.le_d && right_flags.le_v) begin
          val_next = right_val;
        end else if (flags.le_v && !right_flags.le_v) begin
          val_next = v;
        end
      end
      MODE_UP: begin
        if (!left_flags.le_v && flags.le_d) begin
          val_next = left_val;
        end else if (!flags.le_v && left_flags.le_v) begin
          val_next = v;
        end
      end
      default: val_next = val;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      val <= val_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/smw_chain.sv @@
`default_nettype none
module smw_chain #(
  parameter int WINDOW_MAX = smw_pkg::WINDOW_MAX_DEFAULT,
  parameter int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
  input  wire logic               clk,
  input  wire smw_pkg::smw_ctrl_t ctrl,
  input  wire logic [CNT_W-1:0]   fill,
  input  wire smw_pkg::sample_t   v,
  input  wire smw_pkg::sample_t   d,
  input  wire logic               pick,
  input  wire logic [CNT_W-1:0]   lo_idx,
  input  wire logic [CNT_W-1:0]   hi_idx,
  output smw_pkg::sample_t        lo_val,
  output smw_pkg::sample_t        hi_val
);
  import smw_pkg::*;

  sample_t    ext_val [WINDOW_MAX+2];
  smw_flags_t ext_flg [WINDOW_MAX+2];
  sample_t    cell_val [WINDOW_MAX];
  smw_flags_t cell_flg [WINDOW_MAX];
  sample_t    lo_sel;
  sample_t    hi_sel;

  assign ext_val[0]            = '0;
  assign ext_flg[0]            = '{le_d: 1'b1, le_v: 1'b1};
  assign ext_val[WINDOW_MAX+1] = '0;
  assign ext_flg[WINDOW_MAX+1] = '{le_d: 1'b0, le_v: 1'b0};

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    assign ext_val[i+1] = cell_val[i];
    assign ext_flg[i+1] = cell_flg[i];

    smw_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .valid      (CNT_W'(i) < fill),
      .v          (v),
      .d          (d),
      .left_val   (ext_val[i]),
      .left_flags (ext_flg[i]),
      .right_val  (ext_val[i+2]),
      .right_flags(ext_flg[i+2]),
      .val        (cell_val[i]),
      .flags      (cell_flg[i])
    );
  end

  always_comb begin
    lo_sel = '0;
    hi_sel = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      if (lo_idx == CNT_W'(i)) lo_sel = lo_sel | cell_val[i];
      if (hi_idx == CNT_W'(i)) hi_sel = hi_sel | cell_val[i];
    end
  end

  always_ff @(posedge clk) begin
    if (pick) begin
      lo_val <= lo_sel;
      hi_val <= hi_sel;
    end
  end

endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import smw_pkg::*;

  localparam int WIN_MAX = WINDOW_MAX_DEFAULT;
  localparam int CYCLE_LIMIT = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int CHOKE_CYCLES = 200;
  localparam int PHASES = 12;
  localparam sample_t SMAX = sample_t'(32'h7FFF_FFFF);
  localparam sample_t SMIN = sample_t'(32'h8000_0000);

  typedef struct {
    sample_t value;
    logic    restart;
  } sample_item_t;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  sample_t sample = '0;
  logic restart = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [MEDIAN_W-1:0] median_twice;
  logic cfg_wr_en = 1'b0;
  logic [WSIZE_W-1:0] cfg_wr_data = '0;

  sliding_window_median i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample(sample),
    .restart(restart),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .median_twice(median_twice),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  sample_item_t pending_samples[$];
  logic signed [MEDIAN_W-1:0] expected_medians[$];

  sample_t win_ring [WIN_MAX];
  sample_t win_sorted [WIN_MAX];
  int unsigned win_fill = 0;
  int unsigned win_pos = 0;
  logic [WSIZE_W-1:0] win_size = WSIZE_RESET;

  int mismatches = 0;
  int accepted_samples = 0;
  int checked_medians = 0;
  int window_writes = 0;
  int cycle_count = 0;

  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned choke_left;
  int next_choke;
  logic calm_in;
  logic calm_out;

  logic [WSIZE_W-1:0] phase_sizes [PHASES] =
    '{7'd1, 7'd0, 7'd5, 7'd64, 7'd4, 7'd127, 7'd2, 7'd8, 7'd65, 7'd3, 7'd6, 7'd33};
  int phase_items [PHASES] = '{40, 30, 50, 110, 50, 70, 40, 50, 60, 40, 50, 50};

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("ERROR cycle %0d: %s", cycle_count, what);
  endtask

  function automatic int unsigned clamp_window(input logic [WSIZE_W-1:0] size);
    if (size < 1) return 1;
    if (size > WIN_MAX) return WIN_MAX;
    return size;
  endfunction

  function automatic bit predict_median(input sample_t s, input logic rs,
                                        output logic signed [MEDIAN_W-1:0] med);
    int unsigned w;
    int unsigned i;
    sample_t lo;
    sample_t hi;
    w = clamp_window(win_size);
    if (rs) begin
      win_fill = 0;
      win_pos = 0;
    end
    if (win_pos >= w) win_pos = 0;
    if (win_fill > w) begin
      win_fill = 0;
      win_pos = 0;
    end
    // drop the oldest sample from the sorted store
    if (win_fill == w) begin
      i = 0;
      while (i < win_fill && win_sorted[i] != win_ring[win_pos]) i++;
      if (i < win_fill) begin
        while (i + 1 < win_fill) begin
          win_sorted[i] = win_sorted[i + 1];
          i++;
        end
        win_fill--;
      end
    end
    if (win_fill < WIN_MAX) begin
      i = win_fill;
      while (i > 0 && win_sorted[i - 1] > s) begin
        win_sorted[i] = win_sorted[i - 1];
        i--;
      end
      win_sorted[i] = s;
      win_fill++;
    end
    win_ring[win_pos] = s;
    win_pos = (win_pos + 1 >= w) ? 0 : win_pos + 1;
    med = '0;
    if (win_fill < w) return 1'b0;
    if (w % 2 == 1) begin
      lo = win_sorted[w / 2];
      hi = lo;
    end else begin
      lo = win_sorted[w / 2 - 1];
      hi = win_sorted[w / 2];
    end
    med = MEDIAN_W'(lo) + MEDIAN_W'(hi);
    return 1'b1;
  endfunction

  function automatic void push_sample(input sample_t value, input logic rs);
    sample_item_t item;
    item.value = value;
    item.restart = rs;
    pending_samples = {pending_samples, item};
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return sample_t'($urandom);
      4, 5, 6: return sample_t'(int'($urandom_range(0, 8)) - 4);
      7, 8: return sample_t'(int'($urandom_range(0, 2000)) - 1000);
      default: begin
        case ($urandom_range(0, 5))
          0: return SMAX;
          1: return SMIN;
          2: return SMAX - 1;
          3: return SMIN + 1;
          4: return sample_t'(-1);
          default: return sample_t'(0);
        endcase
      end
    endcase
  endfunction

  function automatic void queue_random(input int count, input logic [WSIZE_W-1:0] size);
    int unsigned w;
    w = clamp_window(size);
    for (int k = 0; k < count; k++)
      push_sample(random_sample(), $urandom_range(0, 3 * w + 10) == 0);
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_samples.size() != 0 || in_valid || expected_medians.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_window(input logic [WSIZE_W-1:0] size);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= size;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    win_size = size;
    win_fill = 0;
    win_pos = 0;
    window_writes++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin : driver
    sample_item_t item;
    logic offer;
    logic signed [MEDIAN_W-1:0] med;
    int unsigned gap;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
      calm_in <= 1'b0;
    end else begin
      offer = in_valid;
      gap = gap_left;
      if (in_valid && in_ready) begin
        accepted_samples++;
        if (predict_median(sample, restart, med)) expected_medians = {expected_medians, med};
        offer = 1'b0;
        if ($urandom_range(0, 29) == 0) calm_in <= !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 19);
      end else if (!in_valid && gap != 0) begin
        gap = gap - 1;
      end
      if (!offer && gap == 0 && pending_samples.size() != 0) begin
        item = pending_samples.pop_front();
        sample <= item.value;
        restart <= item.restart;
        offer = 1'b1;
      end
      gap_left <= gap;
      in_valid <= offer;
    end
  end

  always @(posedge clk) begin : monitor
    logic signed [MEDIAN_W-1:0] want;
    logic ready_next;
    int unsigned stall;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      calm_out <= 1'b0;
    end else begin
      ready_next = out_ready;
      if (out_valid && out_ready) begin
        if (expected_medians.size() == 0) begin
          report_mismatch($sformatf("unexpected median_twice %0d", median_twice));
        end else begin
          want = expected_medians.pop_front();
          checked_medians++;
          if (median_twice !== want)
            report_mismatch($sformatf("median_twice got %0d, want %0d", median_twice, want));
        end
        if ($urandom_range(0, 24) == 0) calm_out <= !calm_out;
        stall = calm_out ? 0 : $urandom_range(0, 19);
        hold_left <= stall;
        ready_next = (stall == 0);
      end else if (!out_ready) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
        else ready_next = 1'b1;
      end
      if (choke_left != 0) ready_next = 1'b0;
      out_ready <= ready_next;
    end
  end

  // hold off the receiver for a long stretch so the block backs up
  always @(posedge clk) begin
    if (rst) begin
      choke_left <= 0;
      next_choke <= 120;
    end else if (choke_left != 0) begin
      choke_left <= choke_left - 1;
    end else if (accepted_samples >= next_choke) begin
      choke_left <= CHOKE_CYCLES;
      next_choke <= next_choke + 350;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d medians still pending",
               cycle_count, expected_medians.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    push_sample(SMAX, 1'b1);
    push_sample(SMAX, 1'b0);
    push_sample(SMAX, 1'b0);
    push_sample(SMIN, 1'b0);
    push_sample(SMIN, 1'b0);
    push_sample(SMIN, 1'b0);
    push_sample(sample_t'(0), 1'b0);
    push_sample(sample_t'(-1), 1'b0);
    push_sample(sample_t'(1), 1'b0);
    push_sample(sample_t'(5), 1'b1);
    push_sample(sample_t'(5), 1'b0);
    push_sample(sample_t'(7), 1'b0);
    push_sample(SMAX, 1'b0);
    push_sample(SMIN, 1'b0);
    wait_idle();

    set_window(7'd2);
    push_sample(SMIN, 1'b1);
    push_sample(SMAX, 1'b0);
    push_sample(SMAX, 1'b0);
    push_sample(SMIN, 1'b0);
    push_sample(SMIN, 1'b0);
    push_sample(sample_t'(1), 1'b0);
    push_sample(sample_t'(-2), 1'b0);
    push_sample(sample_t'(3), 1'b1);
    push_sample(sample_t'(4), 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      set_window(phase_sizes[p]);
      queue_random(phase_items[p], phase_sizes[p]);
    end
    wait_idle();

    $display("Run covered %0d samples and %0d checked medians over %0d window size writes,",
             accepted_samples, checked_medians, window_writes);
    $display("window sizes 0 to 127 including saturation, restarts and receiver hold-offs.");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
